// ===== rtl/core/ise_pkg.sv =====
package ise_pkg;

    localparam int unsigned FIELD_W = 32;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic ins;
        logic drain;
    } t_cell_ctl;

endpackage

// ===== rtl/core/ise_if.sv =====
interface ise_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ise_pkg::FIELD_W-1:0] value;
    logic                              final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface ise_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ise_pkg::FIELD_W-1:0] sorted_value;
    logic                              last_of_run;
    logic                              overflowed;

    modport source (output valid, output sorted_value, output last_of_run,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input last_of_run,
                    input overflowed, output ready);
endinterface

// ===== rtl/core/ise_cell.sv =====
module ise_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ise_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_prev_val,
    input  logic                  i_prev_valid,
    input  logic                  i_prev_lt,
    input  logic [DATA_WIDTH-1:0] i_next_val,
    input  logic                  i_next_valid,
    output logic [DATA_WIDTH-1:0] o_val,
    output logic                  o_valid,
    output logic                  o_lt
);

    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] n_val;
    logic                  r_valid;
    logic                  n_valid;

    // strict less-than keeps equal values in arrival order
    assign o_lt = !r_valid || ($signed(i_new) < $signed(r_val));

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.ins && o_lt) begin
            if (i_prev_lt) begin
                n_val   = i_prev_val;
                n_valid = i_prev_valid;
            end else begin
                n_val   = i_new;
                n_valid = 1'b1;
            end
        end else if (i_ctl.drain) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/insertion_sort_engine_unit.sv =====
// Insertion sorter built as a row of compare/shift cells.
// Input channel i_in: one signed value per transfer; final_item closes the set.
// Each accepted value is placed in sorted position in the same cycle, so the
// input side takes one value per cycle while the set is being filled.
// Values that arrive once CAPACITY are held are dropped and the overflow flag
// is raised for the whole set.
// Output channel o_out: after the transfer that carries final_item, results
// start on the next cycle, smallest first, straight from the head cell. The
// row shifts toward the head by one cell on each output transfer.
// last_of_run marks the largest value; overflowed is the same on every
// result of the set.
// No input is taken while a set drains; a stalled receiver simply holds the
// head value and the row in place.
// Reset (synchronous, active low) empties the row and clears the count and
// overflow flag; the block takes input on the first cycle after reset.
module insertion_sort_engine_unit #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ise_in_if.sink    i_in,
    ise_out_if.source o_out
);

    localparam int EFF_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    ise_pkg::t_state    r_state;
    ise_pkg::t_state    n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovf;
    logic               n_ovf;
    ise_pkg::t_cell_ctl w_ctl;

    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic                   w_full;
    logic signed [EFF_W-1:0] w_in_low;
    logic [DATA_WIDTH-1:0]   w_new;
    logic signed [EFF_W-1:0] w_head_low;

    logic [DATA_WIDTH-1:0] w_val   [CAPACITY];
    logic                  w_valid [CAPACITY];
    logic                  w_lt    [CAPACITY];

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign w_full     = (r_count >= CNT_W'(CAPACITY));

    assign w_in_low = i_in.value[EFF_W-1:0];
    assign w_new    = DATA_WIDTH'(w_in_low);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_pv;
            logic                  w_pvld;
            logic                  w_plt;
            logic [DATA_WIDTH-1:0] w_nv;
            logic                  w_nvld;
            if (g == 0) begin : g_head
                assign w_pv   = '0;
                assign w_pvld = 1'b0;
                assign w_plt  = 1'b0;
            end else begin : g_body
                assign w_pv   = w_val[g-1];
                assign w_pvld = w_valid[g-1];
                assign w_plt  = w_lt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_nv   = '0;
                assign w_nvld = 1'b0;
            end else begin : g_mid
                assign w_nv   = w_val[g+1];
                assign w_nvld = w_valid[g+1];
            end
            ise_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_prev_val   (w_pv),
                .i_prev_valid (w_pvld),
                .i_prev_lt    (w_plt),
                .i_next_val   (w_nv),
                .i_next_valid (w_nvld),
                .o_val        (w_val[g]),
                .o_valid      (w_valid[g]),
                .o_lt         (w_lt[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ise_pkg::ST_FILL: begin
                if (w_in_xfer && i_in.final_item) begin
                    n_state = ise_pkg::ST_DRAIN;
                end
            end
            ise_pkg::ST_DRAIN: begin
                if (w_out_xfer && (r_count == CNT_W'(1))) begin
                    n_state = ise_pkg::ST_FILL;
                end
            end
            default: n_state = ise_pkg::ST_FILL;
        endcase
    end

    // outputs and controls
    always_comb begin
        i_in.ready   = 1'b0;
        o_out.valid  = 1'b0;
        w_ctl.ins    = 1'b0;
        w_ctl.drain  = 1'b0;
        case (r_state)
            ise_pkg::ST_FILL: begin
                i_in.ready = 1'b1;
                w_ctl.ins  = w_in_xfer && !w_full;
            end
            ise_pkg::ST_DRAIN: begin
                o_out.valid = 1'b1;
                w_ctl.drain = w_out_xfer;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_in_xfer) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_out_xfer) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ise_pkg::ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign w_head_low         = w_val[0][EFF_W-1:0];
    assign o_out.sorted_value = ise_pkg::FIELD_W'(w_head_low);
    assign o_out.last_of_run  = (r_count == CNT_W'(1));
    assign o_out.overflowed   = r_ovf;

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_count != '0) && w_valid[0])
        else $error("draining with empty row");

    a_full_sets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_full) |=> r_ovf)
        else $error("dropped value did not raise overflow");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out.last_of_run) |=>
            (r_state == ise_pkg::ST_FILL) && (r_count == '0) && !r_ovf && !w_valid[0])
        else $error("row not empty after last transfer");

    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.final_item) |=> o_out.valid)
        else $error("closed set did not start draining");

endmodule
